FILE: rtl/core/hid_keyboard_report_builder_assert.svh
// assertion macros shared by the report builder
`ifndef HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH

// same-cycle implication
`define HKRB_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("hkrb: same-cycle check failed");

// next-cycle implication
`define HKRB_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("hkrb: next-cycle check failed");

`endif

FILE: rtl/core/hkrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hkrb_pkg;

   // field widths
   localparam int REQ_TYPE_W  = 3;
   localparam int KEY_VALUE_W = 16;
   localparam int KEY_CODE_W  = 8;
   localparam int MOD_W       = 8;
   localparam int USAGE_W     = 8;
   localparam int MEDIA_W     = 16;
   localparam int MAX_SLOTS   = 6;

   // key code map
   localparam logic [KEY_CODE_W-1:0] RAW_BASE  = 8'd136;
   localparam logic [MOD_W-1:0]      SHIFT_MOD = 8'h02;

   // request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_KEY_PRESS     = 3'd0,
      REQ_KEY_RELEASE   = 3'd1,
      REQ_MEDIA_PRESS   = 3'd2,
      REQ_MEDIA_RELEASE = 3'd3,
      REQ_RELEASE_ALL   = 3'd4,
      REQ_KEY_TAP       = 3'd5,
      REQ_MEDIA_TAP     = 3'd6
   } req_code_type;

   // report kinds
   localparam logic KIND_KEYBOARD = 1'b0;
   localparam logic KIND_MEDIA    = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND_FIRST,
      ST_SEND_LAST
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic second;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic two_phase;
   } status_type;

   // ascii to usage, top bit means add left shift
   localparam logic [7:0] ASCII_ROM [128] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
      8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
      8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
      8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
      8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
      8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
      8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
      8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
   };

endpackage

`default_nettype wire

FILE: rtl/core/hkrb_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface hkrb_req_if;
   logic                              valid;
   logic                              ready;
   logic [hkrb_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [hkrb_pkg::KEY_VALUE_W-1:0]  key_value;
   logic                              link_up;

   modport source (output valid, req_type, key_value, link_up, input ready);
   modport sink   (input valid, req_type, key_value, link_up, output ready);
endinterface

// report channel
interface hkrb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          report_kind;
   logic                          report_sent;
   logic                          accepted;
   logic [hkrb_pkg::MOD_W-1:0]    modifier_bits;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_a;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_b;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_c;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_d;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_e;
   logic [hkrb_pkg::USAGE_W-1:0]  slot_f;
   logic [hkrb_pkg::MEDIA_W-1:0]  media_bits;
   logic                          last_of_run;

   modport source (output valid, report_kind, report_sent, accepted, modifier_bits,
                   slot_a, slot_b, slot_c, slot_d, slot_e, slot_f, media_bits,
                   last_of_run, input ready);
   modport sink   (input valid, report_kind, report_sent, accepted, modifier_bits,
                   slot_a, slot_b, slot_c, slot_d, slot_e, slot_f, media_bits,
                   last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hid_keyboard_report_builder.sv
// Keyboard report builder with six-key rollover and a 16-bit media mask. Each
// request transaction yields one report transaction (press, release, media
// press, media release) or two (release all: keyboard then media; key tap and
// media tap: press phase then release phase); last_of_run marks the final one.
// The request is worked in the cycle it is taken and its result sits in the
// response register the next cycle; a second result is computed in the cycle
// the first one leaves. The single response register carries one result per
// cycle while the output is ready; a new request is taken in the cycle the
// last result of the previous one is taken. Every result carries the full
// keyboard and media state after its phase. State is cleared by reset at once,
// with no clearing pass. KEY_SLOTS (1 to 6) sets how many key slots are used;
// the rest read as zero.
`timescale 1ns / 1ps
`default_nettype none
`include "hid_keyboard_report_builder_assert.svh"

module hid_keyboard_report_builder #(
   parameter int KEY_SLOTS = 6
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hkrb_req_if.sink   req_chan,
   hkrb_rsp_if.source rsp_chan
);

   hkrb_pkg::cmd_type    cmd;
   hkrb_pkg::status_type status;

   // sequencing
   hkrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // report state and result register
   hkrb_datapath #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_chan.req_type),
      .key_value     (req_chan.key_value),
      .link_up       (req_chan.link_up),
      .cmd           (cmd),
      .status        (status),
      .report_kind   (rsp_chan.report_kind),
      .report_sent   (rsp_chan.report_sent),
      .accepted      (rsp_chan.accepted),
      .modifier_bits (rsp_chan.modifier_bits),
      .slot_a        (rsp_chan.slot_a),
      .slot_b        (rsp_chan.slot_b),
      .slot_c        (rsp_chan.slot_c),
      .slot_d        (rsp_chan.slot_d),
      .slot_e        (rsp_chan.slot_e),
      .slot_f        (rsp_chan.slot_f),
      .media_bits    (rsp_chan.media_bits),
      .last_of_run   (rsp_chan.last_of_run)
   );

   // every request transaction shows a result in the next cycle
   `HKRB_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_chan.valid && req_chan.ready,
                     rsp_chan.valid)

   // a taken first result is followed at once by the second
   `HKRB_ASSERT_NEXT(a_second_follows, clock, reset,
                     rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run,
                     rsp_chan.valid && rsp_chan.last_of_run)

   // no new request while a first result is still pending
   `HKRB_ASSERT_SAME(a_ready_only_last, clock, reset, req_chan.ready && rsp_chan.valid,
                     rsp_chan.last_of_run)

   // media reports always take effect
   `HKRB_ASSERT_SAME(a_media_accepted, clock, reset, rsp_chan.valid && rsp_chan.report_kind,
                     rsp_chan.accepted)

endmodule

`default_nettype wire

FILE: rtl/core/hkrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hkrb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   input  wire hkrb_pkg::status_type status,
   output hkrb_pkg::cmd_type         cmd
);

   hkrb_pkg::state_type state_ff;
   hkrb_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      cmd.start  = 1'b0;
      cmd.second = 1'b0;
      unique case (state_ff)
         hkrb_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.start = 1'b1;
               state_in  = status.two_phase ? hkrb_pkg::ST_SEND_FIRST
                                            : hkrb_pkg::ST_SEND_LAST;
            end
         end
         hkrb_pkg::ST_SEND_FIRST: begin
            out_valid = 1'b1;
            if (out_ready) begin
               // second phase computed as the first result leaves
               cmd.second = 1'b1;
               state_in   = hkrb_pkg::ST_SEND_LAST;
            end
         end
         hkrb_pkg::ST_SEND_LAST: begin
            out_valid = 1'b1;
            in_ready  = out_ready;
            if (out_ready) begin
               if (in_valid) begin
                  cmd.start = 1'b1;
                  state_in  = status.two_phase ? hkrb_pkg::ST_SEND_FIRST
                                               : hkrb_pkg::ST_SEND_LAST;
               end else begin
                  state_in = hkrb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = hkrb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/hkrb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module hkrb_datapath #(
   parameter int KEY_SLOTS = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [hkrb_pkg::REQ_TYPE_W-1:0]     req_type,
   input  wire logic [hkrb_pkg::KEY_VALUE_W-1:0]    key_value,
   input  wire logic                                link_up,
   input  wire hkrb_pkg::cmd_type                   cmd,
   output hkrb_pkg::status_type                     status,
   output logic                                     report_kind,
   output logic                                     report_sent,
   output logic                                     accepted,
   output logic [hkrb_pkg::MOD_W-1:0]               modifier_bits,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_a,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_b,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_c,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_d,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_e,
   output logic [hkrb_pkg::USAGE_W-1:0]             slot_f,
   output logic [hkrb_pkg::MEDIA_W-1:0]             media_bits,
   output logic                                     last_of_run
);

   // report state
   logic [hkrb_pkg::MOD_W-1:0]    mod_ff,   mod_in;
   logic [hkrb_pkg::USAGE_W-1:0]  slots_ff [KEY_SLOTS];
   logic [hkrb_pkg::USAGE_W-1:0]  slots_in [KEY_SLOTS];
   logic [hkrb_pkg::MEDIA_W-1:0]  media_ff, media_in;

   // request held for the second phase
   logic [hkrb_pkg::REQ_TYPE_W-1:0]  type_ff;
   logic [hkrb_pkg::KEY_VALUE_W-1:0] value_ff;
   logic                             link_ff;
   logic                             press_acc_ff;

   // result flags
   logic kind_ff, kind_in;
   logic sent_ff;
   logic acc_ff, acc_in;
   logic last_ff, last_in;
   logic due_in;

   // operands of the current phase
   logic [hkrb_pkg::REQ_TYPE_W-1:0]  op_type;
   logic [hkrb_pkg::KEY_VALUE_W-1:0] op_value;
   logic [hkrb_pkg::KEY_CODE_W-1:0]  op_code;
   logic                             op_link;

   // code map
   logic [7:0]                    rom_entry;
   logic                          mapped;
   logic [hkrb_pkg::MOD_W-1:0]    mod_bit;
   logic [hkrb_pkg::USAGE_W-1:0]  usage;

   // slot search
   logic [KEY_SLOTS-1:0]          match_vec;
   logic [KEY_SLOTS-1:0]          free_vec;
   logic                          any_match;
   logic                          any_free;
   logic                          filled;

   // press and release outcomes
   logic [hkrb_pkg::MOD_W-1:0]    press_mod, rel_mod;
   logic [hkrb_pkg::USAGE_W-1:0]  press_slots [KEY_SLOTS];
   logic [hkrb_pkg::USAGE_W-1:0]  rel_slots   [KEY_SLOTS];
   logic                          press_ok;
   logic                          rel_ok;

   logic [hkrb_pkg::USAGE_W-1:0]  slot_view [hkrb_pkg::MAX_SLOTS];

   // two results for release all and both taps
   assign status.two_phase = (req_type == hkrb_pkg::REQ_RELEASE_ALL) ||
                             (req_type == hkrb_pkg::REQ_KEY_TAP) ||
                             (req_type == hkrb_pkg::REQ_MEDIA_TAP);

   // operand select: new request on start, held request on second phase
   always_comb begin
      op_type  = cmd.start ? req_type  : type_ff;
      op_value = cmd.start ? key_value : value_ff;
      op_link  = cmd.start ? link_up   : link_ff;
      op_code  = op_value[hkrb_pkg::KEY_CODE_W-1:0];
   end

   // key code to usage and modifier bit
   always_comb begin
      rom_entry = hkrb_pkg::ASCII_ROM[op_code[6:0]];
      mapped    = 1'b1;
      mod_bit   = '0;
      usage     = '0;
      if (op_code >= hkrb_pkg::RAW_BASE) begin
         usage = op_code - hkrb_pkg::RAW_BASE;
      end else if (op_code[7]) begin
         mod_bit = hkrb_pkg::MOD_W'(1) << op_code[2:0];
      end else begin
         mapped  = (rom_entry != 8'h00);
         mod_bit = rom_entry[7] ? hkrb_pkg::SHIFT_MOD : '0;
         usage   = {1'b0, rom_entry[6:0]};
      end
   end

   // slot compare against the mapped usage
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         match_vec[i] = (usage != '0) && (slots_ff[i] == usage);
         free_vec[i]  = (slots_ff[i] == '0);
      end
      any_match = |match_vec;
      any_free  = |free_vec;
   end

   // press: fill first free slot unless already held
   always_comb begin
      press_mod = mapped ? (mod_ff | mod_bit) : mod_ff;
      filled    = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         press_slots[i] = slots_ff[i];
         if (mapped && (usage != '0) && !any_match && free_vec[i] && !filled) begin
            press_slots[i] = usage;
            filled         = 1'b1;
         end
      end
      press_ok = mapped && ((usage == '0) || any_match || any_free);
   end

   // release: clear every matching slot
   always_comb begin
      rel_mod = mapped ? (mod_ff & ~mod_bit) : mod_ff;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         rel_slots[i] = (mapped && match_vec[i]) ? '0 : slots_ff[i];
      end
      rel_ok = mapped;
   end

   // phase result
   always_comb begin
      mod_in   = mod_ff;
      slots_in = slots_ff;
      media_in = media_ff;
      kind_in  = hkrb_pkg::KIND_KEYBOARD;
      due_in   = 1'b1;
      acc_in   = 1'b1;
      last_in  = 1'b1;
      unique case (op_type)
         hkrb_pkg::REQ_KEY_PRESS: begin
            mod_in   = press_mod;
            slots_in = press_slots;
            due_in   = press_ok;
            acc_in   = press_ok;
         end
         hkrb_pkg::REQ_KEY_RELEASE: begin
            mod_in   = rel_mod;
            slots_in = rel_slots;
            due_in   = rel_ok;
            acc_in   = rel_ok;
         end
         hkrb_pkg::REQ_MEDIA_PRESS: begin
            media_in = media_ff | op_value;
            kind_in  = hkrb_pkg::KIND_MEDIA;
         end
         hkrb_pkg::REQ_MEDIA_RELEASE: begin
            media_in = media_ff & ~op_value;
            kind_in  = hkrb_pkg::KIND_MEDIA;
         end
         hkrb_pkg::REQ_RELEASE_ALL: begin
            if (cmd.second) begin
               kind_in = hkrb_pkg::KIND_MEDIA;
            end else begin
               mod_in   = '0;
               media_in = '0;
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots_in[i] = '0;
               end
               last_in = 1'b0;
            end
         end
         hkrb_pkg::REQ_KEY_TAP: begin
            if (cmd.second) begin
               mod_in   = rel_mod;
               slots_in = rel_slots;
               due_in   = rel_ok;
               acc_in   = press_acc_ff;
            end else begin
               mod_in   = press_mod;
               slots_in = press_slots;
               due_in   = press_ok;
               acc_in   = press_ok;
               last_in  = 1'b0;
            end
         end
         hkrb_pkg::REQ_MEDIA_TAP: begin
            kind_in = hkrb_pkg::KIND_MEDIA;
            if (cmd.second) begin
               media_in = media_ff & ~op_value;
            end else begin
               media_in = media_ff | op_value;
               last_in  = 1'b0;
            end
         end
         default: begin
            due_in = 1'b0;
            acc_in = 1'b0;
         end
      endcase
   end

   // report state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff   <= '0;
         media_ff <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (cmd.start || cmd.second) begin
         mod_ff   <= mod_in;
         media_ff <= media_in;
         slots_ff <= slots_in;
      end
   end

   // held request and result flags
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         type_ff      <= req_type;
         value_ff     <= key_value;
         link_ff      <= link_up;
         press_acc_ff <= acc_in;
      end
      if (cmd.start || cmd.second) begin
         kind_ff <= kind_in;
         sent_ff <= due_in && op_link;
         acc_ff  <= acc_in;
         last_ff <= last_in;
      end
   end

   // slots past the configured count read as empty
   for (genvar g = 0; g < hkrb_pkg::MAX_SLOTS; g++) begin : g_view
      if (g < KEY_SLOTS) begin : g_used
         assign slot_view[g] = slots_ff[g];
      end else begin : g_unused
         assign slot_view[g] = '0;
      end
   end

   assign report_kind   = kind_ff;
   assign report_sent   = sent_ff;
   assign accepted      = acc_ff;
   assign last_of_run   = last_ff;
   assign modifier_bits = mod_ff;
   assign media_bits    = media_ff;
   assign slot_a        = slot_view[0];
   assign slot_b        = slot_view[1];
   assign slot_c        = slot_view[2];
   assign slot_d        = slot_view[3];
   assign slot_e        = slot_view[4];
   assign slot_f        = slot_view[5];

endmodule

`default_nettype wire
